// File: src/i8080s_pkg.sv
// types, constants and decode functions for the 8080-subset core
// used by every module of the core, no dependencies
`default_nettype none

package i8080s_pkg;

    localparam logic [1:0] ITEM_WRITE = 2'd0;
    localparam logic [1:0] ITEM_READ  = 2'd1;
    localparam logic [1:0] ITEM_EXEC  = 2'd2;

    localparam int FL_CY = 0;
    localparam int FL_P  = 1;
    localparam int FL_AC = 2;
    localparam int FL_Z  = 3;
    localparam int FL_S  = 4;

    localparam logic [2:0] REG_M = 3'd6;
    localparam logic [2:0] REG_A = 3'd7;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] address;
        logic [7:0]  data;
    } req_t;

    typedef struct packed {
        logic        status;
        logic [7:0]  read_data;
        logic [15:0] program_counter;
        logic [15:0] stack_pointer;
        logic [7:0]  accumulator;
        logic [7:0]  flag_word;
        logic [15:0] pair_bc;
        logic [15:0] pair_de;
        logic [15:0] pair_hl;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_WR, ST_RD, ST_RDL, ST_F0, ST_F1, ST_F2, ST_F3,
        ST_M0, ST_M1, ST_M2, ST_W0, ST_W1, ST_EX, ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        AS_PC, AS_PC1, AS_PC2, AS_ITEM, AS_RD0, AS_RD1, AS_WR0, AS_WR1
    } addr_src_t;

    typedef enum logic [2:0] {
        LT_NONE, LT_OP, LT_B1, LT_B2, LT_LO, LT_HI, LT_RDATA
    } latch_t;

    typedef struct packed {
        addr_src_t asel;
        logic      we;
        latch_t    lat;
        logic      commit;
        logic      take;
    } ctl_cmd_t;

    typedef struct packed {
        logic [1:0] rd_cnt;
        logic [1:0] wr_cnt;
        logic       halted;
    } dp_stat_t;

    typedef enum logic [4:0] {
        C_NOP, C_LXI, C_INX, C_DCR, C_MVI, C_DAD, C_LDAX, C_RRC, C_STA, C_LDA,
        C_MOV, C_ANA, C_XRA, C_POP, C_JCC, C_JMP, C_PUSH, C_ADI, C_RET, C_CALL,
        C_OUT, C_ANI, C_XCHG, C_CPI, C_ILL
    } op_class_t;

    function automatic op_class_t classify(input logic [7:0] op);
        op_class_t c;
        c = C_ILL;
        priority if (op == 8'h00)                     c = C_NOP;
        else if ((op & 8'hcf) == 8'h01)               c = C_LXI;
        else if ((op & 8'hcf) == 8'h03)               c = C_INX;
        else if ((op & 8'hc7) == 8'h05)               c = C_DCR;
        else if ((op & 8'hc7) == 8'h06)               c = C_MVI;
        else if ((op & 8'hcf) == 8'h09)               c = C_DAD;
        else if (op == 8'h0a || op == 8'h1a)          c = C_LDAX;
        else if (op == 8'h0f)                         c = C_RRC;
        else if (op == 8'h32)                         c = C_STA;
        else if (op == 8'h3a)                         c = C_LDA;
        else if (op[7:6] == 2'b01 && op != 8'h76)     c = C_MOV;
        else if (op[7:3] == 5'b10100)                 c = C_ANA;
        else if (op[7:3] == 5'b10101)                 c = C_XRA;
        else if ((op & 8'hcf) == 8'hc1)               c = C_POP;
        else if ((op & 8'hc7) == 8'hc2)               c = C_JCC;
        else if (op == 8'hc3)                         c = C_JMP;
        else if ((op & 8'hcf) == 8'hc5)               c = C_PUSH;
        else if (op == 8'hc6)                         c = C_ADI;
        else if (op == 8'hc9)                         c = C_RET;
        else if (op == 8'hcd)                         c = C_CALL;
        else if (op == 8'hd3)                         c = C_OUT;
        else if (op == 8'he6)                         c = C_ANI;
        else if (op == 8'heb)                         c = C_XCHG;
        else if (op == 8'hfb)                         c = C_NOP;
        else if (op == 8'hfe)                         c = C_CPI;
        else                                          c = C_ILL;
        return c;
    endfunction

    function automatic logic even_parity(input logic [7:0] v);
        return ~(^v);
    endfunction

endpackage

`default_nettype wire

// File: src/i8080s_ctrl.sv
// sequencer for the 8080-subset core: fetch, operand access, commit
// depends on i8080s_pkg
`default_nettype none

module i8080s_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [1:0]           opcode,
    input  wire i8080s_pkg::dp_stat_t stat,
    output logic                      busy,
    output logic                      done,
    output i8080s_pkg::ctl_cmd_t      cmd
);

    i8080s_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= i8080s_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            i8080s_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (opcode == i8080s_pkg::ITEM_WRITE)
                        state_next = i8080s_pkg::ST_WR;
                    else if (opcode == i8080s_pkg::ITEM_READ)
                        state_next = i8080s_pkg::ST_RD;
                    else if (opcode == i8080s_pkg::ITEM_EXEC && !stat.halted)
                        state_next = i8080s_pkg::ST_F0;
                    else
                        state_next = i8080s_pkg::ST_DONE;
                end
            end
            i8080s_pkg::ST_WR:   state_next = i8080s_pkg::ST_DONE;
            i8080s_pkg::ST_RD:   state_next = i8080s_pkg::ST_RDL;
            i8080s_pkg::ST_RDL:  state_next = i8080s_pkg::ST_DONE;
            i8080s_pkg::ST_F0:   state_next = i8080s_pkg::ST_F1;
            i8080s_pkg::ST_F1:   state_next = i8080s_pkg::ST_F2;
            i8080s_pkg::ST_F2:   state_next = i8080s_pkg::ST_F3;
            i8080s_pkg::ST_F3:
            begin
                if (stat.rd_cnt != 2'd0)
                    state_next = i8080s_pkg::ST_M0;
                else if (stat.wr_cnt != 2'd0)
                    state_next = i8080s_pkg::ST_W0;
                else
                    state_next = i8080s_pkg::ST_EX;
            end
            i8080s_pkg::ST_M0:   state_next = i8080s_pkg::ST_M1;
            i8080s_pkg::ST_M1:   state_next = i8080s_pkg::ST_M2;
            i8080s_pkg::ST_M2:
            begin
                state_next = (stat.wr_cnt != 2'd0) ? i8080s_pkg::ST_W0 : i8080s_pkg::ST_EX;
            end
            i8080s_pkg::ST_W0:
            begin
                state_next = (stat.wr_cnt == 2'd2) ? i8080s_pkg::ST_W1 : i8080s_pkg::ST_EX;
            end
            i8080s_pkg::ST_W1:   state_next = i8080s_pkg::ST_EX;
            i8080s_pkg::ST_EX:   state_next = i8080s_pkg::ST_DONE;
            i8080s_pkg::ST_DONE: state_next = i8080s_pkg::ST_IDLE;
            default:             state_next = i8080s_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.asel   = i8080s_pkg::AS_PC;
        cmd.we     = 1'b0;
        cmd.lat    = i8080s_pkg::LT_NONE;
        cmd.commit = 1'b0;
        cmd.take   = 1'b0;
        busy       = (state_reg != i8080s_pkg::ST_IDLE);
        done       = 1'b0;
        unique case (state_reg)
            i8080s_pkg::ST_IDLE: cmd.take = start;
            i8080s_pkg::ST_WR:
            begin
                cmd.asel = i8080s_pkg::AS_ITEM;
                cmd.we   = 1'b1;
            end
            i8080s_pkg::ST_RD:   cmd.asel = i8080s_pkg::AS_ITEM;
            i8080s_pkg::ST_RDL:  cmd.lat = i8080s_pkg::LT_RDATA;
            i8080s_pkg::ST_F0:   cmd.asel = i8080s_pkg::AS_PC;
            i8080s_pkg::ST_F1:
            begin
                cmd.lat  = i8080s_pkg::LT_OP;
                cmd.asel = i8080s_pkg::AS_PC1;
            end
            i8080s_pkg::ST_F2:
            begin
                cmd.lat  = i8080s_pkg::LT_B1;
                cmd.asel = i8080s_pkg::AS_PC2;
            end
            i8080s_pkg::ST_F3:   cmd.lat = i8080s_pkg::LT_B2;
            i8080s_pkg::ST_M0:   cmd.asel = i8080s_pkg::AS_RD0;
            i8080s_pkg::ST_M1:
            begin
                cmd.lat  = i8080s_pkg::LT_LO;
                cmd.asel = i8080s_pkg::AS_RD1;
            end
            i8080s_pkg::ST_M2:   cmd.lat = i8080s_pkg::LT_HI;
            i8080s_pkg::ST_W0:
            begin
                cmd.asel = i8080s_pkg::AS_WR0;
                cmd.we   = 1'b1;
            end
            i8080s_pkg::ST_W1:
            begin
                cmd.asel = i8080s_pkg::AS_WR1;
                cmd.we   = 1'b1;
            end
            i8080s_pkg::ST_EX:   cmd.commit = 1'b1;
            i8080s_pkg::ST_DONE: done = 1'b1;
            default:             cmd.lat = i8080s_pkg::LT_NONE;
        endcase
    end

endmodule

`default_nettype wire

// File: src/i8080s_dp.sv
// datapath of the 8080-subset core: byte memory, register file, alu
// depends on i8080s_pkg, driven by i8080s_ctrl
`default_nettype none

module i8080s_dp #(
    parameter int ADDR_BITS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire i8080s_pkg::req_t     request,
    input  wire i8080s_pkg::ctl_cmd_t cmd,
    output i8080s_pkg::dp_stat_t      stat,
    output i8080s_pkg::rsp_t          result
);

    logic [7:0] mem [2**ADDR_BITS];
    logic [7:0] mem_q;

    logic [7:0]  acc_reg, acc_next;
    logic [7:0]  gr_reg [6];
    logic [7:0]  gr_next [6];
    logic [15:0] pc_reg, pc_next;
    logic [15:0] sp_reg, sp_next;
    logic [4:0]  fl_reg, fl_next;
    logic        halt_reg, halt_next;
    logic [7:0]  rdata_reg;
    logic [7:0]  op_reg, b1_reg, b2_reg, lo_reg, hi_reg;
    logic [15:0] iaddr_reg;
    logic [7:0]  idata_reg;

    i8080s_pkg::op_class_t cls;
    logic [2:0]  dst, src;
    logic [1:0]  rp;
    logic [15:0] w, bc, de, hl, rp_val, rd_base, wr_base, maddr, v16, ret;
    logic [7:0]  src_val, dst_val, rval, wd0, wd1, mem_wd, fw, lres;
    logic        rwr, cflag, cond;
    logic        pw_en;
    logic [15:0] pw_val;
    logic [16:0] s17;
    logic [8:0]  s9;

    assign bc  = {gr_reg[0], gr_reg[1]};
    assign de  = {gr_reg[2], gr_reg[3]};
    assign hl  = {gr_reg[4], gr_reg[5]};
    assign w   = {b2_reg, b1_reg};
    assign dst = op_reg[5:3];
    assign src = op_reg[2:0];
    assign rp  = op_reg[5:4];
    assign cls = i8080s_pkg::classify(op_reg);
    assign fw  = {fl_reg[i8080s_pkg::FL_S], fl_reg[i8080s_pkg::FL_Z], 1'b0,
                  fl_reg[i8080s_pkg::FL_AC], 1'b0, fl_reg[i8080s_pkg::FL_P], 1'b1,
                  fl_reg[i8080s_pkg::FL_CY]};
    assign ret = pc_reg + 16'd3;

    function automatic logic [7:0] sel_r(input logic [2:0] code, input logic [7:0] a,
                                         input logic [7:0] m, input logic [7:0] g0,
                                         input logic [7:0] g1, input logic [7:0] g2,
                                         input logic [7:0] g3, input logic [7:0] g4,
                                         input logic [7:0] g5);
        logic [7:0] r;
        unique case (code)
            3'd0:    r = g0;
            3'd1:    r = g1;
            3'd2:    r = g2;
            3'd3:    r = g3;
            3'd4:    r = g4;
            3'd5:    r = g5;
            3'd6:    r = m;
            default: r = a;
        endcase
        return r;
    endfunction

    assign src_val = sel_r(src, acc_reg, lo_reg, gr_reg[0], gr_reg[1], gr_reg[2],
                           gr_reg[3], gr_reg[4], gr_reg[5]);
    assign dst_val = sel_r(dst, acc_reg, lo_reg, gr_reg[0], gr_reg[1], gr_reg[2],
                           gr_reg[3], gr_reg[4], gr_reg[5]);

    always_comb
    begin
        unique case (rp)
            2'd0:    rp_val = bc;
            2'd1:    rp_val = de;
            2'd2:    rp_val = hl;
            default: rp_val = sp_reg;
        endcase
        unique case (op_reg[5:4])
            2'd0:    cflag = fl_reg[i8080s_pkg::FL_Z];
            2'd1:    cflag = fl_reg[i8080s_pkg::FL_CY];
            2'd2:    cflag = fl_reg[i8080s_pkg::FL_P];
            default: cflag = fl_reg[i8080s_pkg::FL_S];
        endcase
        cond = op_reg[3] ? cflag : !cflag;
    end

    // operand counts and addresses
    always_comb
    begin
        stat.halted = halt_reg;
        stat.rd_cnt = 2'd0;
        stat.wr_cnt = 2'd0;
        rd_base     = hl;
        wr_base     = hl;
        v16         = (rp == 2'd3) ? {acc_reg, fw} : rp_val;
        wd0         = 8'd0;
        wd1         = 8'd0;
        unique case (cls)
            i8080s_pkg::C_DCR:
            begin
                stat.rd_cnt = (dst == i8080s_pkg::REG_M) ? 2'd1 : 2'd0;
                stat.wr_cnt = (dst == i8080s_pkg::REG_M) ? 2'd1 : 2'd0;
                wd0         = dst_val - 8'd1;
            end
            i8080s_pkg::C_MVI:
            begin
                stat.wr_cnt = (dst == i8080s_pkg::REG_M) ? 2'd1 : 2'd0;
                wd0         = b1_reg;
            end
            i8080s_pkg::C_LDAX:
            begin
                stat.rd_cnt = 2'd1;
                rd_base     = rp_val;
            end
            i8080s_pkg::C_STA:
            begin
                stat.wr_cnt = 2'd1;
                wr_base     = w;
                wd0         = acc_reg;
            end
            i8080s_pkg::C_LDA:
            begin
                stat.rd_cnt = 2'd1;
                rd_base     = w;
            end
            i8080s_pkg::C_MOV:
            begin
                stat.rd_cnt = (src == i8080s_pkg::REG_M) ? 2'd1 : 2'd0;
                stat.wr_cnt = (dst == i8080s_pkg::REG_M) ? 2'd1 : 2'd0;
                wd0         = src_val;
            end
            i8080s_pkg::C_ANA, i8080s_pkg::C_XRA:
            begin
                stat.rd_cnt = (src == i8080s_pkg::REG_M) ? 2'd1 : 2'd0;
            end
            i8080s_pkg::C_POP, i8080s_pkg::C_RET:
            begin
                stat.rd_cnt = 2'd2;
                rd_base     = sp_reg;
            end
            i8080s_pkg::C_PUSH:
            begin
                stat.wr_cnt = 2'd2;
                wr_base     = sp_reg - 16'd1;
                wd0         = v16[15:8];
                wd1         = v16[7:0];
            end
            i8080s_pkg::C_CALL:
            begin
                stat.wr_cnt = 2'd2;
                wr_base     = sp_reg - 16'd1;
                wd0         = ret[15:8];
                wd1         = ret[7:0];
            end
            default:
            begin
                stat.rd_cnt = 2'd0;
            end
        endcase
    end

    always_comb
    begin
        unique case (cmd.asel)
            i8080s_pkg::AS_PC:   maddr = pc_reg;
            i8080s_pkg::AS_PC1:  maddr = pc_reg + 16'd1;
            i8080s_pkg::AS_PC2:  maddr = pc_reg + 16'd2;
            i8080s_pkg::AS_ITEM: maddr = iaddr_reg;
            i8080s_pkg::AS_RD0:  maddr = rd_base;
            i8080s_pkg::AS_RD1:  maddr = rd_base + 16'd1;
            i8080s_pkg::AS_WR0:  maddr = wr_base;
            default:             maddr = sp_reg - 16'd2;
        endcase
        unique case (cmd.asel)
            i8080s_pkg::AS_ITEM: mem_wd = idata_reg;
            i8080s_pkg::AS_WR0:  mem_wd = wd0;
            default:             mem_wd = wd1;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.we)
        begin
            mem[maddr[ADDR_BITS-1:0]] <= mem_wd;
        end
        mem_q <= mem[maddr[ADDR_BITS-1:0]];
    end

    // instruction commit
    always_comb
    begin
        acc_next  = acc_reg;
        gr_next   = gr_reg;
        pc_next   = pc_reg;
        sp_next   = sp_reg;
        fl_next   = fl_reg;
        halt_next = halt_reg;
        rwr       = 1'b0;
        rval      = 8'd0;
        lres      = 8'd0;
        pw_en     = 1'b0;
        pw_val    = 16'd0;
        s17       = {1'b0, hl} + {1'b0, rp_val};
        s9        = {1'b0, acc_reg} + {1'b0, b1_reg};
        unique case (cls)
            i8080s_pkg::C_NOP: pc_next = pc_reg + 16'd1;
            i8080s_pkg::C_OUT: pc_next = pc_reg + 16'd2;
            i8080s_pkg::C_LXI, i8080s_pkg::C_INX:
            begin
                pw_en   = 1'b1;
                pw_val  = (cls == i8080s_pkg::C_LXI) ? w : rp_val + 16'd1;
                pc_next = pc_reg + ((cls == i8080s_pkg::C_LXI) ? 16'd3 : 16'd1);
            end
            i8080s_pkg::C_DCR:
            begin
                rwr  = 1'b1;
                rval = dst_val - 8'd1;
                fl_next[i8080s_pkg::FL_S] = rval[7];
                fl_next[i8080s_pkg::FL_Z] = (rval == 8'd0);
                fl_next[i8080s_pkg::FL_P] = i8080s_pkg::even_parity(rval);
                pc_next = pc_reg + 16'd1;
            end
            i8080s_pkg::C_MVI:
            begin
                rwr     = 1'b1;
                rval    = b1_reg;
                pc_next = pc_reg + 16'd2;
            end
            i8080s_pkg::C_DAD:
            begin
                gr_next[4] = s17[15:8];
                gr_next[5] = s17[7:0];
                fl_next[i8080s_pkg::FL_CY] = s17[16];
                pc_next = pc_reg + 16'd1;
            end
            i8080s_pkg::C_LDAX:
            begin
                acc_next = lo_reg;
                pc_next  = pc_reg + 16'd1;
            end
            i8080s_pkg::C_RRC:
            begin
                acc_next = {acc_reg[0], acc_reg[7:1]};
                fl_next[i8080s_pkg::FL_CY] = acc_reg[0];
                pc_next = pc_reg + 16'd1;
            end
            i8080s_pkg::C_STA: pc_next = pc_reg + 16'd3;
            i8080s_pkg::C_LDA:
            begin
                acc_next = lo_reg;
                pc_next  = pc_reg + 16'd3;
            end
            i8080s_pkg::C_MOV:
            begin
                rwr     = 1'b1;
                rval    = src_val;
                pc_next = pc_reg + 16'd1;
            end
            i8080s_pkg::C_ANA, i8080s_pkg::C_XRA, i8080s_pkg::C_ANI:
            begin
                if (cls == i8080s_pkg::C_ANA)
                    lres = acc_reg & src_val;
                else if (cls == i8080s_pkg::C_XRA)
                    lres = acc_reg ^ src_val;
                else
                    lres = acc_reg & b1_reg;
                acc_next = lres;
                fl_next[i8080s_pkg::FL_S]  = lres[7];
                fl_next[i8080s_pkg::FL_Z]  = (lres == 8'd0);
                fl_next[i8080s_pkg::FL_P]  = i8080s_pkg::even_parity(lres);
                fl_next[i8080s_pkg::FL_CY] = 1'b0;
                pc_next = pc_reg + ((cls == i8080s_pkg::C_ANI) ? 16'd2 : 16'd1);
            end
            i8080s_pkg::C_POP:
            begin
                if (rp == 2'd3)
                begin
                    fl_next  = {lo_reg[7], lo_reg[6], lo_reg[4], lo_reg[2], lo_reg[0]};
                    acc_next = hi_reg;
                end
                else
                begin
                    pw_en  = 1'b1;
                    pw_val = {hi_reg, lo_reg};
                end
                sp_next = sp_reg + 16'd2;
                pc_next = pc_reg + 16'd1;
            end
            i8080s_pkg::C_JCC: pc_next = cond ? w : pc_reg + 16'd3;
            i8080s_pkg::C_JMP: pc_next = w;
            i8080s_pkg::C_PUSH:
            begin
                sp_next = sp_reg - 16'd2;
                pc_next = pc_reg + 16'd1;
            end
            i8080s_pkg::C_ADI:
            begin
                acc_next = s9[7:0];
                fl_next[i8080s_pkg::FL_S]  = s9[7];
                fl_next[i8080s_pkg::FL_Z]  = (s9[7:0] == 8'd0);
                fl_next[i8080s_pkg::FL_P]  = i8080s_pkg::even_parity(s9[7:0]);
                fl_next[i8080s_pkg::FL_CY] = s9[8];
                pc_next = pc_reg + 16'd2;
            end
            i8080s_pkg::C_RET:
            begin
                pc_next = {hi_reg, lo_reg};
                sp_next = sp_reg + 16'd2;
            end
            i8080s_pkg::C_CALL:
            begin
                sp_next = sp_reg - 16'd2;
                pc_next = w;
            end
            i8080s_pkg::C_XCHG:
            begin
                gr_next[2] = gr_reg[4];
                gr_next[3] = gr_reg[5];
                gr_next[4] = gr_reg[2];
                gr_next[5] = gr_reg[3];
                pc_next    = pc_reg + 16'd1;
            end
            i8080s_pkg::C_CPI:
            begin
                lres = acc_reg - b1_reg;
                fl_next[i8080s_pkg::FL_S]  = lres[7];
                fl_next[i8080s_pkg::FL_Z]  = (lres == 8'd0);
                fl_next[i8080s_pkg::FL_P]  = i8080s_pkg::even_parity(lres);
                fl_next[i8080s_pkg::FL_CY] = (acc_reg < b1_reg);
                pc_next = pc_reg + 16'd2;
            end
            default: halt_next = 1'b1;
        endcase
        // register pair write
        if (pw_en)
        begin
            unique case (rp)
                2'd0:
                begin
                    gr_next[0] = pw_val[15:8];
                    gr_next[1] = pw_val[7:0];
                end
                2'd1:
                begin
                    gr_next[2] = pw_val[15:8];
                    gr_next[3] = pw_val[7:0];
                end
                2'd2:
                begin
                    gr_next[4] = pw_val[15:8];
                    gr_next[5] = pw_val[7:0];
                end
                default: sp_next = pw_val;
            endcase
        end
        if (rwr)
        begin
            unique case (dst)
                3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5: gr_next[dst] = rval;
                i8080s_pkg::REG_A:                  acc_next = rval;
                default:                            acc_next = acc_next;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= 8'd0;
            gr_reg    <= '{default: 8'd0};
            pc_reg    <= 16'd0;
            sp_reg    <= 16'd0;
            fl_reg    <= 5'd0;
            halt_reg  <= 1'b0;
            rdata_reg <= 8'd0;
        end
        else
        begin
            if (cmd.commit)
            begin
                acc_reg  <= acc_next;
                gr_reg   <= gr_next;
                pc_reg   <= pc_next;
                sp_reg   <= sp_next;
                fl_reg   <= fl_next;
                halt_reg <= halt_next;
            end
            if (cmd.take)
                rdata_reg <= 8'd0;
            else if (cmd.lat == i8080s_pkg::LT_RDATA)
                rdata_reg <= mem_q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            iaddr_reg <= request.address;
            idata_reg <= request.data;
        end
        unique case (cmd.lat)
            i8080s_pkg::LT_OP: op_reg <= mem_q;
            i8080s_pkg::LT_B1: b1_reg <= mem_q;
            i8080s_pkg::LT_B2: b2_reg <= mem_q;
            i8080s_pkg::LT_LO: lo_reg <= mem_q;
            i8080s_pkg::LT_HI: hi_reg <= mem_q;
            default:           op_reg <= op_reg;
        endcase
    end

    assign result.status          = halt_reg;
    assign result.read_data       = rdata_reg;
    assign result.program_counter = pc_reg;
    assign result.stack_pointer   = sp_reg;
    assign result.accumulator     = acc_reg;
    assign result.flag_word       = fw;
    assign result.pair_bc         = bc;
    assign result.pair_de         = de;
    assign result.pair_hl         = hl;

endmodule

`default_nettype wire

// File: src/i8080_subset_instruction_core.sv
// top level of the 8080-subset core: sequencer plus datapath
// depends on i8080s_pkg, i8080s_ctrl, i8080s_dp
//
// channel   signals                 direction  handshake
// request   start, busy, request    in         taken when start and not busy
// result    done, result            out        one-cycle strobe, no back-pressure
//
// states from the accepting cycle through the done cycle; memory write: write, done;
// memory read: read, latch, done; idle item or item while halted: done directly
// execute: fetch, operand read states if an operand is read (one or two bytes), write
// states per stored byte (0 to 2), commit, done; the single-port byte memory sets this
// reset clears registers, flags, pc, sp and the halt flag; memory is not cleared
// one request at a time; done marks the result for exactly one cycle
`default_nettype none

module i8080_subset_instruction_core #(
    parameter int ADDR_BITS = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire i8080s_pkg::req_t request,
    output logic                  done,
    output i8080s_pkg::rsp_t      result
);

    i8080s_pkg::ctl_cmd_t cmd;
    i8080s_pkg::dp_stat_t stat;

    i8080s_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (request.opcode),
        .stat   (stat),
        .busy   (busy),
        .done   (done),
        .cmd    (cmd)
    );

    i8080s_dp #(
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .stat    (stat),
        .result  (result)
    );

endmodule

`default_nettype wire

// File: src/i8080s_chk.sv
// port-level checks for the 8080-subset core, bound to the top level
// depends on i8080s_pkg
`default_nettype none

module i8080s_chk (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic             done,
    input wire i8080s_pkg::rsp_t result
);

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe outside a request");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but core not busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_end_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(done))
        else $error("request ended without a result");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(result.status) |-> result.status)
        else $error("halt flag cleared without reset");

endmodule

bind i8080_subset_instruction_core i8080s_chk u_chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .result  (result)
);

`default_nettype wire

// File: bench/tb_top.sv
// self-checking bench for the 8080-subset core: directed and random request streams
// keeps its own model of the core in a small scoreboard class; depends on i8080s_pkg
`timescale 1ns / 100ps

module tb_top;

    localparam logic [1:0] ITEM_IDLE = 2'd3;
    localparam logic [7:0] OP_BAD    = 8'h76;
    localparam int STALL_LIMIT = 2000;
    localparam int ITEM_TARGET = 1950;

    class core_scoreboard;
        bit [7:0]  mem [65536];
        bit        seen [65536];
        bit [15:0] seen_list [$];
        bit [7:0]  acc;
        bit [7:0]  regs [6];
        bit [15:0] pc;
        bit [15:0] sp;
        bit [4:0]  fl;
        bit        halted;
        i8080s_pkg::rsp_t expected_q [$];
        int        errors;

        function i8080s_pkg::op_class_t kind_of(bit [7:0] op);
            if (op == 8'h00 || op == 8'hfb) return i8080s_pkg::C_NOP;
            if ((op & 8'hcf) == 8'h01) return i8080s_pkg::C_LXI;
            if ((op & 8'hcf) == 8'h03) return i8080s_pkg::C_INX;
            if ((op & 8'hc7) == 8'h05) return i8080s_pkg::C_DCR;
            if ((op & 8'hc7) == 8'h06) return i8080s_pkg::C_MVI;
            if ((op & 8'hcf) == 8'h09) return i8080s_pkg::C_DAD;
            if (op == 8'h0a || op == 8'h1a) return i8080s_pkg::C_LDAX;
            if (op == 8'h0f) return i8080s_pkg::C_RRC;
            if (op == 8'h32) return i8080s_pkg::C_STA;
            if (op == 8'h3a) return i8080s_pkg::C_LDA;
            if (op[7:6] == 2'b01 && op != OP_BAD) return i8080s_pkg::C_MOV;
            if (op[7:3] == 5'b10100) return i8080s_pkg::C_ANA;
            if (op[7:3] == 5'b10101) return i8080s_pkg::C_XRA;
            if ((op & 8'hcf) == 8'hc1) return i8080s_pkg::C_POP;
            if ((op & 8'hc7) == 8'hc2) return i8080s_pkg::C_JCC;
            if (op == 8'hc3) return i8080s_pkg::C_JMP;
            if ((op & 8'hcf) == 8'hc5) return i8080s_pkg::C_PUSH;
            if (op == 8'hc6) return i8080s_pkg::C_ADI;
            if (op == 8'hc9) return i8080s_pkg::C_RET;
            if (op == 8'hcd) return i8080s_pkg::C_CALL;
            if (op == 8'hd3) return i8080s_pkg::C_OUT;
            if (op == 8'he6) return i8080s_pkg::C_ANI;
            if (op == 8'heb) return i8080s_pkg::C_XCHG;
            if (op == 8'hfe) return i8080s_pkg::C_CPI;
            return i8080s_pkg::C_ILL;
        endfunction

        function bit [7:0] rd(bit [15:0] a);
            return mem[a];
        endfunction

        function void wr(bit [15:0] a, bit [7:0] v);
            mem[a] = v;
            if (!seen[a])
            begin
                seen[a] = 1'b1;
                seen_list.push_back(a);
            end
        endfunction

        function bit [15:0] pair_of(int hi);
            return {regs[hi], regs[hi+1]};
        endfunction

        function void set_pair(int hi, bit [15:0] v);
            regs[hi] = v[15:8];
            regs[hi+1] = v[7:0];
        endfunction

        function bit [7:0] get_r(bit [2:0] r);
            if (r == i8080s_pkg::REG_M) return rd(pair_of(4));
            if (r == i8080s_pkg::REG_A) return acc;
            return regs[r];
        endfunction

        function void set_r(bit [2:0] r, bit [7:0] v);
            if (r == i8080s_pkg::REG_M) wr(pair_of(4), v);
            else if (r == i8080s_pkg::REG_A) acc = v;
            else regs[r] = v;
        endfunction

        function bit [15:0] rp_get(bit [1:0] rp);
            return rp == 2'd3 ? sp : pair_of(rp * 2);
        endfunction

        function void rp_set(bit [1:0] rp, bit [15:0] v);
            if (rp == 2'd3) sp = v;
            else set_pair(rp * 2, v);
        endfunction

        function void set_szp(bit [7:0] v);
            fl[i8080s_pkg::FL_S] = v[7];
            fl[i8080s_pkg::FL_Z] = (v == 8'h00);
            fl[i8080s_pkg::FL_P] = ~(^v);
        endfunction

        function bit [7:0] flag_byte();
            return {fl[i8080s_pkg::FL_S], fl[i8080s_pkg::FL_Z], 1'b0, fl[i8080s_pkg::FL_AC],
                    1'b0, fl[i8080s_pkg::FL_P], 1'b1, fl[i8080s_pkg::FL_CY]};
        endfunction

        function void run_instruction();
            bit [7:0]  op;
            bit [7:0]  b1;
            bit [15:0] w;
            bit [1:0]  rp;
            bit [2:0]  dst;
            bit [2:0]  src;
            bit [7:0]  v;
            bit [7:0]  hi;
            bit [16:0] sum;
            bit [15:0] t;
            bit        f;
            op = rd(pc);
            b1 = rd(pc + 16'd1);
            w = {rd(pc + 16'd2), b1};
            rp = op[5:4];
            dst = op[5:3];
            src = op[2:0];
            unique case (kind_of(op))
                i8080s_pkg::C_NOP: pc = pc + 16'd1;
                i8080s_pkg::C_LXI:
                begin
                    rp_set(rp, w);
                    pc = pc + 16'd3;
                end
                i8080s_pkg::C_INX:
                begin
                    rp_set(rp, rp_get(rp) + 16'd1);
                    pc = pc + 16'd1;
                end
                i8080s_pkg::C_DCR:
                begin
                    v = get_r(dst) - 8'd1;
                    set_r(dst, v);
                    set_szp(v);
                    pc = pc + 16'd1;
                end
                i8080s_pkg::C_MVI:
                begin
                    pc = pc + 16'd2;
                    set_r(dst, b1);
                end
                i8080s_pkg::C_DAD:
                begin
                    sum = {1'b0, pair_of(4)} + {1'b0, rp_get(rp)};
                    set_pair(4, sum[15:0]);
                    fl[i8080s_pkg::FL_CY] = sum[16];
                    pc = pc + 16'd1;
                end
                i8080s_pkg::C_LDAX:
                begin
                    acc = rd(rp_get(rp));
                    pc = pc + 16'd1;
                end
                i8080s_pkg::C_RRC:
                begin
                    fl[i8080s_pkg::FL_CY] = acc[0];
                    acc = {acc[0], acc[7:1]};
                    pc = pc + 16'd1;
                end
                i8080s_pkg::C_STA:
                begin
                    wr(w, acc);
                    pc = pc + 16'd3;
                end
                i8080s_pkg::C_LDA:
                begin
                    acc = rd(w);
                    pc = pc + 16'd3;
                end
                i8080s_pkg::C_MOV:
                begin
                    set_r(dst, get_r(src));
                    pc = pc + 16'd1;
                end
                i8080s_pkg::C_ANA, i8080s_pkg::C_XRA:
                begin
                    acc = kind_of(op) == i8080s_pkg::C_ANA ? acc & get_r(src)
                                                           : acc ^ get_r(src);
                    set_szp(acc);
                    fl[i8080s_pkg::FL_CY] = 1'b0;
                    pc = pc + 16'd1;
                end
                i8080s_pkg::C_POP:
                begin
                    v = rd(sp);
                    hi = rd(sp + 16'd1);
                    if (rp == 2'd3)
                    begin
                        fl = {v[7], v[6], v[4], v[2], v[0]};
                        acc = hi;
                    end
                    else
                        set_pair(rp * 2, {hi, v});
                    sp = sp + 16'd2;
                    pc = pc + 16'd1;
                end
                i8080s_pkg::C_JCC:
                begin
                    unique case (dst[2:1])
                        2'd0: f = fl[i8080s_pkg::FL_Z];
                        2'd1: f = fl[i8080s_pkg::FL_CY];
                        2'd2: f = fl[i8080s_pkg::FL_P];
                        default: f = fl[i8080s_pkg::FL_S];
                    endcase
                    pc = (dst[0] ? f : !f) ? w : pc + 16'd3;
                end
                i8080s_pkg::C_JMP: pc = w;
                i8080s_pkg::C_PUSH:
                begin
                    t = rp == 2'd3 ? {acc, flag_byte()} : pair_of(rp * 2);
                    wr(sp - 16'd1, t[15:8]);
                    wr(sp - 16'd2, t[7:0]);
                    sp = sp - 16'd2;
                    pc = pc + 16'd1;
                end
                i8080s_pkg::C_ADI:
                begin
                    sum = {9'd0, acc} + {9'd0, b1};
                    acc = sum[7:0];
                    set_szp(acc);
                    fl[i8080s_pkg::FL_CY] = sum[8];
                    pc = pc + 16'd2;
                end
                i8080s_pkg::C_RET:
                begin
                    pc = {rd(sp + 16'd1), rd(sp)};
                    sp = sp + 16'd2;
                end
                i8080s_pkg::C_CALL:
                begin
                    t = pc + 16'd3;
                    wr(sp - 16'd1, t[15:8]);
                    wr(sp - 16'd2, t[7:0]);
                    sp = sp - 16'd2;
                    pc = w;
                end
                i8080s_pkg::C_OUT: pc = pc + 16'd2;
                i8080s_pkg::C_ANI:
                begin
                    acc = acc & b1;
                    set_szp(acc);
                    fl[i8080s_pkg::FL_CY] = 1'b0;
                    pc = pc + 16'd2;
                end
                i8080s_pkg::C_XCHG:
                begin
                    t = pair_of(4);
                    set_pair(4, pair_of(2));
                    set_pair(2, t);
                    pc = pc + 16'd1;
                end
                i8080s_pkg::C_CPI:
                begin
                    v = acc - b1;
                    set_szp(v);
                    fl[i8080s_pkg::FL_CY] = acc < b1;
                    pc = pc + 16'd2;
                end
                default: halted = 1'b1;
            endcase
        endfunction

        function void note(i8080s_pkg::req_t r);
            i8080s_pkg::rsp_t e;
            e = '0;
            if (r.opcode == i8080s_pkg::ITEM_WRITE) wr(r.address, r.data);
            else if (r.opcode == i8080s_pkg::ITEM_READ) e.read_data = rd(r.address);
            else if (r.opcode == i8080s_pkg::ITEM_EXEC && !halted) run_instruction();
            e.status = halted;
            e.program_counter = pc;
            e.stack_pointer = sp;
            e.accumulator = acc;
            e.flag_word = flag_byte();
            e.pair_bc = pair_of(0);
            e.pair_de = pair_of(2);
            e.pair_hl = pair_of(4);
            expected_q.push_back(e);
        endfunction

        function void field(string name, bit [15:0] e, logic [15:0] g);
            if (g !== e)
            begin
                $display("%0t mismatch %s expected %h actual %h", $time, name, e, g);
                errors++;
            end
        endfunction

        function void check(i8080s_pkg::rsp_t g);
            i8080s_pkg::rsp_t e;
            if (expected_q.size() == 0)
            begin
                $display("%0t unexpected result actual %h", $time, g);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            field("status", 16'(e.status), 16'(g.status));
            field("read_data", 16'(e.read_data), 16'(g.read_data));
            field("program_counter", e.program_counter, g.program_counter);
            field("stack_pointer", e.stack_pointer, g.stack_pointer);
            field("accumulator", 16'(e.accumulator), 16'(g.accumulator));
            field("flag_word", 16'(e.flag_word), 16'(g.flag_word));
            field("pair_bc", e.pair_bc, g.pair_bc);
            field("pair_de", e.pair_de, g.pair_de);
            field("pair_hl", e.pair_hl, g.pair_hl);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    i8080s_pkg::req_t request;
    i8080s_pkg::rsp_t result;

    core_scoreboard sb;
    int  n_items;
    int  stall_cycles;
    bit  no_gaps;

    i8080_subset_instruction_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .done(done),
        .result(result)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (done) sb.check(result);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles == STALL_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic send(i8080s_pkg::req_t r);
        int gap;
        gap = no_gaps ? 0 : int'($urandom_range(0, 19));
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        request <= r;
        do @(posedge clk); while (busy);
        sb.note(r);
        n_items++;
    endtask

    task automatic issue(bit [1:0] opc, bit [15:0] a, bit [7:0] d);
        i8080s_pkg::req_t r;
        r.opcode = opc;
        r.address = a;
        r.data = d;
        send(r);
    endtask

    task automatic fill(bit [15:0] a);
        if (!sb.seen[a]) issue(i8080s_pkg::ITEM_WRITE, a, 8'($urandom_range(0, 255)));
    endtask

    task automatic exec_op(bit [7:0] op, bit [7:0] b1, bit [7:0] b2);
        bit [15:0] p;
        p = sb.pc;
        if (!sb.halted)
        begin
            issue(i8080s_pkg::ITEM_WRITE, p, op);
            issue(i8080s_pkg::ITEM_WRITE, p + 16'd1, b1);
            issue(i8080s_pkg::ITEM_WRITE, p + 16'd2, b2);
            fill(sb.pair_of(0));
            fill(sb.pair_of(2));
            fill(sb.pair_of(4));
            fill(sb.sp);
            fill(sb.sp + 16'd1);
            fill({b2, b1});
        end
        issue(i8080s_pkg::ITEM_EXEC, 16'($urandom_range(0, 65535)),
              8'($urandom_range(0, 255)));
    endtask

    task automatic exec_random(bit [7:0] op);
        bit [15:0] w;
        if ($urandom_range(0, 1) && sb.seen_list.size() > 0)
            w = sb.seen_list[$urandom_range(0, sb.seen_list.size() - 1)];
        else
            w = 16'($urandom_range(0, 65535));
        exec_op(op, w[7:0], w[15:8]);
    endtask

    task automatic wait_drained();
        while (sb.expected_q.size() > 0) @(posedge clk);
    endtask

    localparam bit [7:0] DIRECTED_PROG [24] = '{
        8'h31, 8'h01, 8'h21, 8'h03, 8'h35, 8'h36, 8'h39, 8'h0a, 8'h1a, 8'h0f,
        8'h32, 8'h3a, 8'h4e, 8'ha6, 8'haf, 8'hf5, 8'hf1, 8'hca, 8'hc6, 8'hcd,
        8'hc9, 8'hd3, 8'he6, 8'hfe
    };

    initial
    begin
        bit [7:0] op;
        int k;
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        n_items = 0;
        stall_cycles = 0;
        no_gaps = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // field extremes and the idle item code
        issue(i8080s_pkg::ITEM_WRITE, 16'hffff, 8'hff);
        issue(i8080s_pkg::ITEM_WRITE, 16'h0000, 8'h00);
        issue(i8080s_pkg::ITEM_READ, 16'hffff, 8'h00);
        issue(ITEM_IDLE, 16'hffff, 8'hff);
        foreach (DIRECTED_PROG[i])
            exec_op(DIRECTED_PROG[i], 8'hff, 8'hff);
        exec_op(8'heb, 8'h00, 8'h00);
        exec_op(8'hfb, 8'h00, 8'h00);
        exec_op(8'hc3, 8'h00, 8'h80);

        start <= 1'b0;
        wait_drained();

        while (n_items < ITEM_TARGET)
        begin
            if ($urandom_range(0, 49) == 0) no_gaps = ~no_gaps;
            k = int'($urandom_range(0, 19));
            if (k < 15)
            begin
                do op = 8'($urandom_range(0, 255));
                while (sb.kind_of(op) == i8080s_pkg::C_ILL);
                exec_random(op);
            end
            else if (k < 17)
                issue(i8080s_pkg::ITEM_WRITE, 16'($urandom_range(0, 65535)),
                      8'($urandom_range(0, 255)));
            else if (k < 19)
                issue(i8080s_pkg::ITEM_READ,
                      sb.seen_list[$urandom_range(0, sb.seen_list.size() - 1)],
                      8'($urandom_range(0, 255)));
            else
                issue(ITEM_IDLE, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
        end

        // unimplemented opcode halts the core; memory items keep working
        exec_op(OP_BAD, 8'h00, 8'h00);
        exec_op(8'h00, 8'h00, 8'h00);
        issue(i8080s_pkg::ITEM_WRITE, 16'h1234, 8'h5a);
        issue(i8080s_pkg::ITEM_READ, 16'h1234, 8'h00);
        issue(ITEM_IDLE, 16'h0000, 8'h00);

        start <= 1'b0;
        wait_drained();
        repeat (30) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
